// ----- hdl/gda_pkg.sv -----
// ----------------------------------------------------------------------------
// gda_pkg: shared types and constants for the Gregorian date unit
// Command and status bundles between controller and datapath, field widths,
// code constants and the month tables.
// ----------------------------------------------------------------------------
package gda_pkg;

  localparam int YEAR_W  = 14;
  localparam int MON_W   = 4;
  localparam int DAY_W   = 5;
  localparam int DIFF_W  = 23;
  localparam int CODE_W  = 2;

  localparam int OUT_W       = YEAR_W + MON_W + DAY_W + DIFF_W + CODE_W + CODE_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // floor(y / 100) for any 14-bit y as (y * RECIP_100) >> RECIP_SHIFT.
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int RPROD_W     = 27;
  localparam int Q_W         = RPROD_W - RECIP_SHIFT;
  localparam int Y365_W      = YEAR_W + 9;

  localparam int DAYS_YEAR = 365;
  localparam int DAYS_4Y   = 1461;
  localparam int DAYS_100Y = 36524;
  localparam int DAYS_400Y = 146097;
  localparam int DIFF_MAX  = 4194303;

  localparam logic [CODE_W-1:0] FUNC_ADD = 2'd0;
  localparam logic [CODE_W-1:0] FUNC_SUB = 2'd1;
  localparam logic [CODE_W-1:0] FUNC_CMP = 2'd2;

  localparam logic [CODE_W-1:0] ORD_EQUAL   = 2'd0;
  localparam logic [CODE_W-1:0] ORD_LATER   = 2'd1;
  localparam logic [CODE_W-1:0] ORD_EARLIER = 2'd2;

  localparam logic [CODE_W-1:0] STS_OK       = 2'd0;
  localparam logic [CODE_W-1:0] STS_BAD_DATE = 2'd1;
  localparam logic [CODE_W-1:0] STS_RANGE    = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_SUM,
    OP_COMBINE,
    OP_EVAL,
    OP_DIV_STEP,
    OP_FINISH
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_SUM_A,
    ST_MUL_B,
    ST_SUM_B,
    ST_COMBINE,
    ST_EVAL,
    ST_DIV,
    ST_DONE
  } ctl_state_e;

  typedef enum logic [2:0] {
    PH_Q400,
    PH_Q100,
    PH_Q4,
    PH_Q1,
    PH_MON,
    PH_END
  } div_phase_e;

  typedef struct packed {
    dp_op_e op;
    logic   sel_other;
  } dp_cmd_t;

  typedef struct packed {
    logic is_cmp;
    logic need_div;
    logic div_done;
    logic out_busy;
  } dp_status_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] mo,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (mo)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the first of the month in a common year.
  function automatic logic [8:0] cum_days(input logic [MON_W-1:0] mo);
    logic [8:0] c;
    case (mo)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/gda_ctrl.sv -----
// ----------------------------------------------------------------------------
// gda_ctrl: sequencing controller of the Gregorian date unit
// Steps the datapath through day-count conversion, combination, evaluation,
// the calendar split loop and hand-over to the output register.
// ----------------------------------------------------------------------------
module gda_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  gda_pkg::dp_status_t sts_i,
  output gda_pkg::dp_cmd_t    cmd_o
);

  gda_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gda_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    s_ready_o       = 1'b0;
    cmd_o.op        = gda_pkg::OP_NONE;
    cmd_o.sel_other = 1'b0;
    case (state_q)
      gda_pkg::ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.op = gda_pkg::OP_LOAD;
          state_d  = gda_pkg::ST_MUL_A;
        end
      end
      gda_pkg::ST_MUL_A: begin
        cmd_o.op = gda_pkg::OP_MUL;
        state_d  = gda_pkg::ST_SUM_A;
      end
      gda_pkg::ST_SUM_A: begin
        cmd_o.op = gda_pkg::OP_SUM;
        state_d  = sts_i.is_cmp ? gda_pkg::ST_MUL_B : gda_pkg::ST_COMBINE;
      end
      gda_pkg::ST_MUL_B: begin
        cmd_o.op        = gda_pkg::OP_MUL;
        cmd_o.sel_other = 1'b1;
        state_d         = gda_pkg::ST_SUM_B;
      end
      gda_pkg::ST_SUM_B: begin
        cmd_o.op        = gda_pkg::OP_SUM;
        cmd_o.sel_other = 1'b1;
        state_d         = gda_pkg::ST_COMBINE;
      end
      gda_pkg::ST_COMBINE: begin
        cmd_o.op = gda_pkg::OP_COMBINE;
        state_d  = gda_pkg::ST_EVAL;
      end
      gda_pkg::ST_EVAL: begin
        cmd_o.op = gda_pkg::OP_EVAL;
        state_d  = sts_i.need_div ? gda_pkg::ST_DIV : gda_pkg::ST_DONE;
      end
      gda_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = gda_pkg::ST_DONE;
        end else begin
          cmd_o.op = gda_pkg::OP_DIV_STEP;
        end
      end
      gda_pkg::ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = gda_pkg::OP_FINISH;
          state_d  = gda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gda_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/gda_datapath.sv -----
// ----------------------------------------------------------------------------
// gda_datapath: datapath of the Gregorian date unit
// Day-count conversion, offset and difference adder, range and order checks,
// the shared subtract-and-count unit that splits a day count into a date,
// and the output register.
// ----------------------------------------------------------------------------
module gda_datapath #(
  parameter int MAX_YEAR    = 9999,
  parameter int OFFSET_BITS = 21
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  gda_pkg::dp_cmd_t                       cmd_i,
  output gda_pkg::dp_status_t                    sts_o,
  input  logic [gda_pkg::CODE_W-1:0]             func_i,
  input  logic [gda_pkg::YEAR_W-1:0]             in_year_i,
  input  logic [gda_pkg::MON_W-1:0]              in_month_i,
  input  logic [gda_pkg::DAY_W-1:0]              in_day_i,
  input  logic signed [OFFSET_BITS-1:0]          offset_i,
  input  logic [gda_pkg::YEAR_W-1:0]             other_year_i,
  input  logic [gda_pkg::MON_W-1:0]              other_month_i,
  input  logic [gda_pkg::DAY_W-1:0]              other_day_i,
  input  logic                                   m_ready_i,
  output logic                                   m_valid_o,
  output logic [gda_pkg::OUT_TDATA_W-1:0]        m_data_o
);

  localparam int MaxDays = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                           + MAX_YEAR / 400 - 1;
  localparam int DAYS_W  = $clog2(MaxDays + 1);
  localparam int N_W     = (DAYS_W > OFFSET_BITS ? DAYS_W : OFFSET_BITS) + 2;
  localparam int SAT_W   = (N_W > gda_pkg::DIFF_W ? N_W : gda_pkg::DIFF_W) + 1;
  localparam int YACC_W  = $clog2(MAX_YEAR + 1);
  localparam int YW      = gda_pkg::YEAR_W;
  localparam int MW      = gda_pkg::MON_W;
  localparam int DW      = gda_pkg::DAY_W;
  localparam int CW      = gda_pkg::CODE_W;
  localparam int QW      = gda_pkg::Q_W;

  // Captured item.
  logic [CW-1:0]                 func_q;
  logic [YW-1:0]                 ya_q, yb_q;
  logic [MW-1:0]                 ma_q, mb_q;
  logic [DW-1:0]                 da_q, db_q;
  logic signed [OFFSET_BITS-1:0] off_q;

  // Day-count conversion.
  logic [YW-1:0]                 yr_q;
  logic [MW-1:0]                 mo_q;
  logic [DW-1:0]                 dy_q;
  logic [gda_pkg::Y365_W-1:0]    y365_q;
  logic [QW-1:0]                 c100_q, p100_q;
  logic [DAYS_W-1:0]             days_a_q, days_b_q;
  logic                          valid_a_q, valid_b_q;
  logic signed [N_W-1:0]         n_q;

  // Calendar split.
  gda_pkg::div_phase_e           phase_q;
  logic [DAYS_W-1:0]             rem_q;
  logic [YACC_W-1:0]             yacc_q;
  logic [1:0]                    q100_q, q1_q;
  logic [4:0]                    q4_q;
  logic [MW-1:0]                 mon_q;

  // Pending result and output register.
  logic [YW-1:0]                 pyear_q, out_year_q;
  logic [MW-1:0]                 pmon_q, out_mon_q;
  logic [DW-1:0]                 pday_q, out_day_q;
  logic [gda_pkg::DIFF_W-1:0]    pdiff_q, out_diff_q;
  logic [CW-1:0]                 porder_q, out_order_q;
  logic [CW-1:0]                 pstatus_q, out_status_q;
  logic                          out_valid_q;

  logic [YW-1:0]                 sel_y, pm1_sel, p_yr;
  logic [MW-1:0]                 sel_m;
  logic [DW-1:0]                 sel_d;
  logic [gda_pkg::RPROD_W-1:0]   prod_c, prod_p;
  logic                          leap, leap_add, date_valid, is_cmp, range_bad, need_div;
  logic [DW-1:0]                 mlen;
  logic [DAYS_W-1:0]             days_sum;
  logic signed [N_W-1:0]         a_ext, b_ext, off_ext, n_d;
  logic signed [SAT_W-1:0]       n_sat_ext;
  logic [gda_pkg::DIFF_W-1:0]    diff_sat;
  logic                          leap_acc, step_ok;
  logic [DAYS_W-1:0]             step_val;
  logic [YACC_W-1:0]             year_inc;

  // ---------------------------------------------------------------- compute
  assign is_cmp = !(func_q == gda_pkg::FUNC_ADD || func_q == gda_pkg::FUNC_SUB);

  assign sel_y   = cmd_i.sel_other ? yb_q : ya_q;
  assign sel_m   = cmd_i.sel_other ? mb_q : ma_q;
  assign sel_d   = cmd_i.sel_other ? db_q : da_q;
  assign pm1_sel = sel_y - YW'(1);
  assign prod_c  = gda_pkg::RPROD_W'(sel_y) * gda_pkg::RPROD_W'(gda_pkg::RECIP_100);
  assign prod_p  = gda_pkg::RPROD_W'(pm1_sel) * gda_pkg::RPROD_W'(gda_pkg::RECIP_100);

  // A year divisible by 4 is leap unless it is a century not divisible by 400.
  assign p_yr     = yr_q - YW'(1);
  assign leap     = (yr_q[1:0] == 2'b00) &&
                    (((YW + 1)'(c100_q) * (YW + 1)'(100) != (YW + 1)'(yr_q)) ||
                     (c100_q[1:0] == 2'b00));
  assign mlen     = gda_pkg::month_len(mo_q, leap);
  assign leap_add = leap && (mo_q > MW'(2));
  assign date_valid = (yr_q != '0) && (int'(yr_q) <= MAX_YEAR) &&
                      (mo_q != '0) && (mo_q <= MW'(12)) &&
                      (dy_q != '0) && (dy_q <= mlen);
  assign days_sum = DAYS_W'(y365_q) + DAYS_W'(p_yr[YW-1:2]) - DAYS_W'(p100_q)
                    + DAYS_W'(p100_q[QW-1:2]) + DAYS_W'(gda_pkg::cum_days(mo_q))
                    + DAYS_W'(leap_add) + DAYS_W'(dy_q) - DAYS_W'(1);

  assign a_ext   = {{(N_W - DAYS_W){1'b0}}, days_a_q};
  assign b_ext   = {{(N_W - DAYS_W){1'b0}}, days_b_q};
  assign off_ext = {{(N_W - OFFSET_BITS){off_q[OFFSET_BITS-1]}}, off_q};

  always_comb begin
    if (is_cmp) begin
      n_d = a_ext - b_ext;
    end else if (func_q == gda_pkg::FUNC_ADD) begin
      n_d = a_ext + off_ext;
    end else begin
      n_d = a_ext - off_ext;
    end
  end

  assign range_bad = n_q[N_W-1] || (n_q > $signed(N_W'(MaxDays)));
  assign need_div  = valid_a_q && !is_cmp && !range_bad;

  assign n_sat_ext = {{(SAT_W - N_W){n_q[N_W-1]}}, n_q};
  always_comb begin
    if (n_sat_ext > $signed(SAT_W'(gda_pkg::DIFF_MAX))) begin
      diff_sat = gda_pkg::DIFF_W'(gda_pkg::DIFF_MAX);
    end else if (n_sat_ext < -$signed(SAT_W'(gda_pkg::DIFF_MAX))) begin
      diff_sat = gda_pkg::DIFF_W'(-gda_pkg::DIFF_MAX);
    end else begin
      diff_sat = n_sat_ext[gda_pkg::DIFF_W-1:0];
    end
  end

  // The accumulated year is leap when it closes a four-year block, except for
  // the last block of a century that is not the fourth century of the cycle.
  assign leap_acc = (q1_q == 2'd3) && ((q4_q != 5'd24) || (q100_q == 2'd3));

  always_comb begin
    step_val = '0;
    year_inc = '0;
    step_ok  = 1'b0;
    case (phase_q)
      gda_pkg::PH_Q400: begin
        step_val = DAYS_W'(gda_pkg::DAYS_400Y);
        year_inc = YACC_W'(400);
        step_ok  = rem_q >= step_val;
      end
      gda_pkg::PH_Q100: begin
        step_val = DAYS_W'(gda_pkg::DAYS_100Y);
        year_inc = YACC_W'(100);
        step_ok  = (rem_q >= step_val) && (q100_q != 2'd3);
      end
      gda_pkg::PH_Q4: begin
        step_val = DAYS_W'(gda_pkg::DAYS_4Y);
        year_inc = YACC_W'(4);
        step_ok  = rem_q >= step_val;
      end
      gda_pkg::PH_Q1: begin
        step_val = DAYS_W'(gda_pkg::DAYS_YEAR);
        year_inc = YACC_W'(1);
        step_ok  = (rem_q >= step_val) && (q1_q != 2'd3);
      end
      gda_pkg::PH_MON: begin
        step_val = DAYS_W'(gda_pkg::month_len(mon_q, leap_acc));
        step_ok  = (rem_q >= step_val) && (mon_q != MW'(12));
      end
      default: begin
        step_ok = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= gda_pkg::PH_END;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == gda_pkg::OP_EVAL) begin
        phase_q <= need_div ? gda_pkg::PH_Q400 : gda_pkg::PH_END;
      end else if (cmd_i.op == gda_pkg::OP_DIV_STEP && !step_ok) begin
        case (phase_q)
          gda_pkg::PH_Q400: phase_q <= gda_pkg::PH_Q100;
          gda_pkg::PH_Q100: phase_q <= gda_pkg::PH_Q4;
          gda_pkg::PH_Q4:   phase_q <= gda_pkg::PH_Q1;
          gda_pkg::PH_Q1:   phase_q <= gda_pkg::PH_MON;
          default:          phase_q <= gda_pkg::PH_END;
        endcase
      end
      if (cmd_i.op == gda_pkg::OP_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == gda_pkg::OP_LOAD) begin
      func_q <= func_i;
      ya_q   <= in_year_i;
      ma_q   <= in_month_i;
      da_q   <= in_day_i;
      off_q  <= offset_i;
      yb_q   <= other_year_i;
      mb_q   <= other_month_i;
      db_q   <= other_day_i;
    end
    if (cmd_i.op == gda_pkg::OP_MUL) begin
      yr_q   <= sel_y;
      mo_q   <= sel_m;
      dy_q   <= sel_d;
      y365_q <= gda_pkg::Y365_W'(pm1_sel) * gda_pkg::Y365_W'(gda_pkg::DAYS_YEAR);
      c100_q <= prod_c[gda_pkg::RPROD_W-1:gda_pkg::RECIP_SHIFT];
      p100_q <= prod_p[gda_pkg::RPROD_W-1:gda_pkg::RECIP_SHIFT];
    end
    if (cmd_i.op == gda_pkg::OP_SUM) begin
      if (cmd_i.sel_other) begin
        days_b_q  <= days_sum;
        valid_b_q <= date_valid;
      end else begin
        days_a_q  <= days_sum;
        valid_a_q <= date_valid;
      end
    end
    if (cmd_i.op == gda_pkg::OP_COMBINE) begin
      n_q <= n_d;
    end
    if (cmd_i.op == gda_pkg::OP_EVAL) begin
      pyear_q  <= ya_q;
      pmon_q   <= ma_q;
      pday_q   <= da_q;
      pdiff_q  <= '0;
      porder_q <= gda_pkg::ORD_EQUAL;
      rem_q    <= n_q[DAYS_W-1:0];
      yacc_q   <= YACC_W'(1);
      q100_q   <= '0;
      q4_q     <= '0;
      q1_q     <= '0;
      mon_q    <= MW'(1);
      if (!valid_a_q) begin
        pstatus_q <= gda_pkg::STS_BAD_DATE;
      end else if (!is_cmp) begin
        pstatus_q <= range_bad ? gda_pkg::STS_RANGE : gda_pkg::STS_OK;
      end else if (!valid_b_q) begin
        pstatus_q <= gda_pkg::STS_BAD_DATE;
      end else begin
        pstatus_q <= gda_pkg::STS_OK;
        pdiff_q   <= diff_sat;
        if (n_q[N_W-1]) begin
          porder_q <= gda_pkg::ORD_EARLIER;
        end else if (n_q != '0) begin
          porder_q <= gda_pkg::ORD_LATER;
        end
      end
    end
    if (cmd_i.op == gda_pkg::OP_DIV_STEP) begin
      if (step_ok) begin
        rem_q  <= rem_q - step_val;
        yacc_q <= yacc_q + year_inc;
        case (phase_q)
          gda_pkg::PH_Q100: q100_q <= q100_q + 2'd1;
          gda_pkg::PH_Q4:   q4_q   <= q4_q + 5'd1;
          gda_pkg::PH_Q1:   q1_q   <= q1_q + 2'd1;
          gda_pkg::PH_MON:  mon_q  <= mon_q + MW'(1);
          default:          q4_q   <= q4_q;
        endcase
      end else if (phase_q == gda_pkg::PH_MON) begin
        pyear_q <= YW'(yacc_q);
        pmon_q  <= mon_q;
        pday_q  <= DW'(rem_q + DAYS_W'(1));
      end
    end
    if (cmd_i.op == gda_pkg::OP_FINISH) begin
      out_year_q   <= pyear_q;
      out_mon_q    <= pmon_q;
      out_day_q    <= pday_q;
      out_diff_q   <= pdiff_q;
      out_order_q  <= porder_q;
      out_status_q <= pstatus_q;
    end
  end

  assign sts_o.is_cmp   = is_cmp;
  assign sts_o.need_div = need_div;
  assign sts_o.div_done = (phase_q == gda_pkg::PH_END);
  assign sts_o.out_busy = out_valid_q && !m_ready_i;

  assign m_valid_o = out_valid_q;
  assign m_data_o  = {{(gda_pkg::OUT_TDATA_W - gda_pkg::OUT_W){1'b0}},
                      out_status_q, out_order_q, out_diff_q,
                      out_day_q, out_mon_q, out_year_q};

  // ---------------------------------------------------------------- checks
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == gda_pkg::OP_FINISH |-> !(out_valid_q && !m_ready_i))
    else $error("result register overwritten before it was taken");

  a_month_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == gda_pkg::PH_MON |-> rem_q <= DAYS_W'(365))
    else $error("day of year out of range in month stepping");

  a_q4_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == gda_pkg::PH_MON |-> q4_q <= 5'd24)
    else $error("four-year count exceeds a century");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != gda_pkg::STS_OK
      |-> out_order_q == gda_pkg::ORD_EQUAL && out_diff_q == '0)
    else $error("failed item carries a difference or an order");

endmodule

// ----- hdl/gregorian_date_arithmetic_top.sv -----
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_top: Gregorian date add, subtract and compare
// Adds or subtracts a signed day offset to a date, or gives the signed day
// difference and ordering of two dates, with range and validity checks.
//
// Use: one item enters on the slave stream (selector in tuser, dates and
// offset in tdata) and one result leaves on the master stream. Items are
// worked one at a time: tready is high only while the unit is idle, so the
// next item can be taken in the cycle after each result is registered.
// A failed or out-of-range add/subtract is converted, combined and evaluated
// before it is handed to the output register; a compare converts both dates
// first, and a successful add/subtract also runs the split loop. The split
// loop subtracts one 400-year cycle, century, four-year block, year or month
// per cycle and closes each of its five stages once its step no longer applies.
// The result sits in an output register; the next item is accepted while it
// waits, and a stalled receiver only holds the unit once the next result is
// ready. Reset clears the controller and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_top #(
  parameter int MAX_YEAR    = 9999,
  parameter int OFFSET_BITS = 21
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // func
  input  logic [gda_pkg::CODE_W-1:0]      s_axis_tuser_i,
  // in_year, in_month, in_day, offset, other_year, other_month, other_day
  input  logic [((46 + OFFSET_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // res_year, res_month, res_day, day_diff, order, status
  output logic [gda_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int OffLsb = gda_pkg::YEAR_W + gda_pkg::MON_W + gda_pkg::DAY_W;
  localparam int OyLsb  = OffLsb + OFFSET_BITS;
  localparam int OmLsb  = OyLsb + gda_pkg::YEAR_W;
  localparam int OdLsb  = OmLsb + gda_pkg::MON_W;

  gda_pkg::dp_cmd_t    cmd;
  gda_pkg::dp_status_t sts;

  gda_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  gda_datapath #(
    .MAX_YEAR    (MAX_YEAR),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (s_axis_tuser_i),
    .in_year_i     (s_axis_tdata_i[gda_pkg::YEAR_W-1:0]),
    .in_month_i    (s_axis_tdata_i[gda_pkg::YEAR_W +: gda_pkg::MON_W]),
    .in_day_i      (s_axis_tdata_i[gda_pkg::YEAR_W + gda_pkg::MON_W +: gda_pkg::DAY_W]),
    .offset_i      ($signed(s_axis_tdata_i[OffLsb +: OFFSET_BITS])),
    .other_year_i  (s_axis_tdata_i[OyLsb +: gda_pkg::YEAR_W]),
    .other_month_i (s_axis_tdata_i[OmLsb +: gda_pkg::MON_W]),
    .other_day_i   (s_axis_tdata_i[OdLsb +: gda_pkg::DAY_W]),
    .m_ready_i     (m_axis_tready_i),
    .m_valid_o     (m_axis_tvalid_o),
    .m_data_o      (m_axis_tdata_o)
  );

endmodule

// ----- dv/gregorian_date_arithmetic_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_top_tb: self-checking bench for the date unit
// Streams directed and random date requests (add, subtract, compare, invalid
// and out-of-range cases) into the unit under varying source and sink
// back-pressure. Every result is checked field by field against a calendar
// predictor built on a day count from the first day of year 1.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_top_tb;
  import gda_pkg::*;

  localparam int MAX_YEAR    = 9999;
  localparam int OFFSET_BITS = 21;
  localparam int IN_TDATA_W  = ((46 + OFFSET_BITS + 7) / 8) * 8;

  // Reserved selector value; the unit treats it as a compare.
  localparam logic [CODE_W-1:0] FUNC_ALT = 2'd3;

  localparam int N_RANDOM   = 930;
  localparam int PHASE1_AT  = 330;
  localparam int PHASE2_AT  = 650;
  localparam int LONG_HOLD  = 300;
  localparam int DRAIN_CYC  = 200;
  localparam int STALL_LIM  = 3000;
  localparam int MAX_REPORT = 10;

  typedef struct {
    logic [CODE_W-1:0]      fn;
    logic [YEAR_W-1:0]      y;
    logic [MON_W-1:0]       m;
    logic [DAY_W-1:0]       d;
    logic [OFFSET_BITS-1:0] off;
    logic [YEAR_W-1:0]      oy;
    logic [MON_W-1:0]       om;
    logic [DAY_W-1:0]       od;
    bit                     hold;
  } date_req_t;

  typedef struct {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
    logic [DIFF_W-1:0] diff;
    logic [CODE_W-1:0] order;
    logic [CODE_W-1:0] status;
  } date_res_t;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [CODE_W-1:0]      s_axis_tuser_i  = '0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  date_req_t req_q[$];
  date_res_t due_q[$];

  bit in_taken = 1'b0;
  int n_in     = 0;
  int n_out    = 0;
  int errors   = 0;
  int n_ok     = 0;
  int n_range  = 0;
  int n_bad    = 0;
  int n_cmp    = 0;

  gregorian_date_arithmetic_top #(
    .MAX_YEAR   (MAX_YEAR),
    .OFFSET_BITS(OFFSET_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- calendar

  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(int y, int m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic bit date_valid(int y, int m, int d);
    if (y < 1 || y > MAX_YEAR || m < 1 || m > 12) return 1'b0;
    return d >= 1 && d <= month_days(y, m);
  endfunction

  // Days elapsed since 0001-01-01.
  function automatic longint day_number(int y, int m, int d);
    longint p;
    longint n;
    p = y - 1;
    n = p * 365 + p / 4 - p / 100 + p / 400;
    for (int k = 1; k < m; k++) n += month_days(y, k);
    return n + d - 1;
  endfunction

  function automatic void split_day_number(input longint num, output int y, output int m,
                                           output int d);
    longint n;
    longint q400, q100, q4, q1;
    n    = num;
    q400 = n / 146097;
    n   -= q400 * 146097;
    q100 = n / 36524;
    if (q100 == 4) q100 = 3;
    n   -= q100 * 36524;
    q4   = n / 1461;
    n   -= q4 * 1461;
    q1   = n / 365;
    if (q1 == 4) q1 = 3;
    n   -= q1 * 365;
    y    = int'(q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1);
    m    = 1;
    while (m < 12 && n >= month_days(y, m)) begin
      n -= month_days(y, m);
      m++;
    end
    d = int'(n + 1);
  endfunction

  function automatic date_res_t calc_date_result(date_req_t rq);
    date_res_t r;
    longint    n;
    longint    dd;
    longint    shift;
    int        ry, rm, rd;
    r.year   = rq.y;
    r.month  = rq.m;
    r.day    = rq.d;
    r.diff   = '0;
    r.order  = ORD_EQUAL;
    r.status = STS_OK;
    shift    = longint'($signed(rq.off));
    if (!date_valid(rq.y, rq.m, rq.d)) begin
      r.status = STS_BAD_DATE;
    end else if (rq.fn == FUNC_ADD || rq.fn == FUNC_SUB) begin
      n = day_number(rq.y, rq.m, rq.d) + ((rq.fn == FUNC_ADD) ? shift : -shift);
      if (n < 0 || n > day_number(MAX_YEAR, 12, 31)) begin
        r.status = STS_RANGE;
      end else begin
        split_day_number(n, ry, rm, rd);
        r.year  = ry[YEAR_W-1:0];
        r.month = rm[MON_W-1:0];
        r.day   = rd[DAY_W-1:0];
      end
    end else if (!date_valid(rq.oy, rq.om, rq.od)) begin
      r.status = STS_BAD_DATE;
    end else begin
      dd      = day_number(rq.y, rq.m, rq.d) - day_number(rq.oy, rq.om, rq.od);
      r.order = (dd > 0) ? ORD_LATER : ((dd < 0) ? ORD_EARLIER : ORD_EQUAL);
      if (dd > DIFF_MAX) dd = DIFF_MAX;
      if (dd < -DIFF_MAX) dd = -DIFF_MAX;
      r.diff = dd[DIFF_W-1:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------- stimulus

  function automatic int src_idle_pct(int n);
    return (n < PHASE1_AT) ? 7 : ((n < PHASE2_AT) ? 71 : 0);
  endfunction

  function automatic int sink_idle_pct(int n);
    return (n < PHASE1_AT) ? 71 : ((n < PHASE2_AT) ? 7 : 0);
  endfunction

  task automatic add_req(logic [CODE_W-1:0] fn, int y, int m, int d, int off,
                         int oy, int om, int od);
    date_req_t rq;
    rq.fn   = fn;
    rq.y    = y[YEAR_W-1:0];
    rq.m    = m[MON_W-1:0];
    rq.d    = d[DAY_W-1:0];
    rq.off  = off[OFFSET_BITS-1:0];
    rq.oy   = oy[YEAR_W-1:0];
    rq.om   = om[MON_W-1:0];
    rq.od   = od[DAY_W-1:0];
    rq.hold = 1'b0;
    req_q.push_back(rq);
  endtask

  function automatic int pick_year();
    case ($urandom_range(9))
      0:       return $urandom_range(1, 4);
      1:       return $urandom_range(MAX_YEAR - 3, MAX_YEAR);
      2:       return 100 * $urandom_range(1, MAX_YEAR / 100);
      default: return $urandom_range(1, MAX_YEAR);
    endcase
  endfunction

  function automatic int pick_day(int y, int m);
    if ($urandom_range(3) == 0) return month_days(y, m);
    return $urandom_range(1, month_days(y, m));
  endfunction

  function automatic int pick_offset();
    int mag;
    case ($urandom_range(3))
      0:       mag = $urandom_range(0, 40);
      1:       mag = $urandom_range(0, 1000);
      2:       mag = $urandom_range(0, 40000);
      default: return $urandom_range(0, (1 << OFFSET_BITS) - 1);
    endcase
    return $urandom_range(1) ? -mag : mag;
  endfunction

  task automatic fill_requests();
    logic [CODE_W-1:0] fn;
    int y, m, d, oy, om, od, sel;
    longint n;
    // Boundaries of the calendar and the offset range.
    add_req(FUNC_ADD, 1, 1, 1, 0, 1, 1, 1);
    add_req(FUNC_SUB, 1, 1, 1, 1, 1, 1, 1);
    add_req(FUNC_ADD, MAX_YEAR, 12, 31, 1, 1, 1, 1);
    add_req(FUNC_ADD, 1, 1, 1, (1 << (OFFSET_BITS - 1)) - 1, 16383, 15, 31);
    add_req(FUNC_ADD, MAX_YEAR, 12, 31, -(1 << (OFFSET_BITS - 1)), 0, 0, 0);
    add_req(FUNC_SUB, 1, 1, 1, -(1 << (OFFSET_BITS - 1)), 1, 1, 1);
    add_req(FUNC_SUB, 2001, 1, 1, 365, 1, 1, 1);
    add_req(FUNC_ADD, 2000, 3, 1, -1, 1, 1, 1);
    // Leap rule: every fourth year, not centuries, but every fourth century.
    add_req(FUNC_ADD, 2000, 2, 28, 1, 1, 1, 1);
    add_req(FUNC_ADD, 1900, 2, 28, 1, 1, 1, 1);
    add_req(FUNC_ADD, 2004, 2, 28, 1, 1, 1, 1);
    // Malformed primary dates.
    add_req(FUNC_ADD, 1900, 2, 29, 5, 1, 1, 1);
    add_req(FUNC_SUB, 2020, 0, 10, 5, 1, 1, 1);
    add_req(FUNC_ADD, 2020, 13, 10, 5, 1, 1, 1);
    add_req(FUNC_CMP, 2020, 15, 10, 0, 2020, 1, 1);
    add_req(FUNC_ADD, 2020, 4, 31, 0, 1, 1, 1);
    add_req(FUNC_SUB, 2020, 5, 0, 0, 1, 1, 1);
    add_req(FUNC_ADD, 0, 5, 5, 0, 1, 1, 1);
    add_req(FUNC_ADD, MAX_YEAR + 1, 1, 1, 0, 1, 1, 1);
    add_req(FUNC_SUB, 16383, 12, 31, 0, 1, 1, 1);
    // Compares: equal, the widest spans both ways, bad second date, spare code.
    add_req(FUNC_CMP, 1600, 2, 29, 0, 1600, 2, 29);
    add_req(FUNC_CMP, MAX_YEAR, 12, 31, 0, 1, 1, 1);
    add_req(FUNC_CMP, 1, 1, 1, 0, MAX_YEAR, 12, 31);
    add_req(FUNC_CMP, 2021, 6, 15, 0, 2021, 2, 29);
    add_req(FUNC_ALT, 1999, 12, 31, 0, 2000, 1, 1);

    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(99) < 15) begin
        // Raw noise over the full width of every field.
        add_req(CODE_W'($urandom_range(3)), $urandom_range(16383), $urandom_range(15),
                $urandom_range(31), $urandom_range(0, (1 << OFFSET_BITS) - 1),
                $urandom_range(16383), $urandom_range(15), $urandom_range(31));
      end else begin
        sel = $urandom_range(99);
        fn  = (sel < 40) ? FUNC_ADD : (sel < 70) ? FUNC_SUB : (sel < 95) ? FUNC_CMP : FUNC_ALT;
        y   = pick_year();
        m   = $urandom_range(1, 12);
        d   = pick_day(y, m);
        if (fn == FUNC_ADD || fn == FUNC_SUB) begin
          add_req(fn, y, m, d, pick_offset(), $urandom_range(16383), $urandom_range(15),
                  $urandom_range(31));
        end else begin
          sel = $urandom_range(9);
          if (sel == 0) begin
            oy = y;
            om = m;
            od = d;
          end else if (sel < 4) begin
            n = day_number(y, m, d) + $urandom_range(0, 60) - 30;
            if (n < 0) n = 0;
            if (n > day_number(MAX_YEAR, 12, 31)) n = day_number(MAX_YEAR, 12, 31);
            split_day_number(n, oy, om, od);
          end else begin
            oy = pick_year();
            om = $urandom_range(1, 12);
            od = pick_day(oy, om);
          end
          add_req(fn, y, m, d, $urandom_range(0, (1 << OFFSET_BITS) - 1), oy, om, od);
        end
      end
    end
    // The source waits for an empty pipeline at each change of pacing.
    req_q[PHASE1_AT].hold = 1'b1;
    req_q[PHASE2_AT].hold = 1'b1;
  endtask

  // ------------------------------------------------------------------ driver

  always @(negedge clk_i) begin : source
    date_req_t rq;
    if (rst_ni && (!s_axis_tvalid_i || in_taken)) begin
      if (req_q.size() != 0 && !(req_q[0].hold && due_q.size() != 0) &&
          $urandom_range(99) >= src_idle_pct(n_in)) begin
        rq = req_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tuser_i  <= rq.fn;
        s_axis_tdata_i  <= IN_TDATA_W'({rq.od, rq.om, rq.oy, rq.off, rq.d, rq.m, rq.y});
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Result sink; it also holds off for a long stretch now and then so that
  // the unit fills up and pushes back on its input.
  int hold_cnt     = 0;
  int next_hold_at = 200;

  always @(negedge clk_i) begin : sink
    if (rst_ni) begin
      if (hold_cnt == 0 && n_in >= next_hold_at) begin
        hold_cnt     = LONG_HOLD;
        next_hold_at += 500;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct(n_in));
      end
    end
  end

  // ----------------------------------------------------------------- monitor

  always @(posedge clk_i) begin : observe
    date_req_t rq;
    date_res_t want;
    date_res_t got;
    in_taken = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (in_taken) begin
      rq.fn  = s_axis_tuser_i;
      rq.y   = s_axis_tdata_i[13:0];
      rq.m   = s_axis_tdata_i[17:14];
      rq.d   = s_axis_tdata_i[22:18];
      rq.off = s_axis_tdata_i[43:23];
      rq.oy  = s_axis_tdata_i[57:44];
      rq.om  = s_axis_tdata_i[61:58];
      rq.od  = s_axis_tdata_i[66:62];
      want   = calc_date_result(rq);
      due_q.push_back(want);
      n_in++;
      if (want.status == STS_BAD_DATE) n_bad++;
      else if (want.status == STS_RANGE) n_range++;
      else if (rq.fn == FUNC_ADD || rq.fn == FUNC_SUB) n_ok++;
      else n_cmp++;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.year   = m_axis_tdata_o[13:0];
      got.month  = m_axis_tdata_o[17:14];
      got.day    = m_axis_tdata_o[22:18];
      got.diff   = m_axis_tdata_o[45:23];
      got.order  = m_axis_tdata_o[47:46];
      got.status = m_axis_tdata_o[49:48];
      n_out++;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORT)
          $display("ERROR: result %0d arrived with nothing outstanding", n_out);
      end else begin
        want = due_q.pop_front();
        if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
            got.diff !== want.diff || got.order !== want.order ||
            got.status !== want.status) begin
          errors++;
          if (errors <= MAX_REPORT) begin
            $display("ERROR: result %0d expected %0d-%0d-%0d diff %0d ord %0d sts %0d",
                     n_out, want.year, want.month, want.day, $signed(want.diff),
                     want.order, want.status);
            $display("       got %0d-%0d-%0d diff %0d ord %0d sts %0d",
                     got.year, got.month, got.day, $signed(got.diff), got.order,
                     got.status);
          end
        end
      end
    end
  end

  int quiet_cyc = 0;

  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cyc = 0;
    else
      quiet_cyc++;
    if (quiet_cyc >= STALL_LIM) begin
      $display("ERROR: no transfer for %0d cycles, %0d results outstanding", quiet_cyc,
               due_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // -------------------------------------------------------------- sequencing

  initial begin
    fill_requests();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (req_q.size() == 0 && !s_axis_tvalid_i);
    wait (due_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
    errors += due_q.size();

    $display("Run covered %0d requests: %0d add/subtract in range, %0d out of range,",
             n_in, n_ok, n_range);
    $display("%0d invalid dates and %0d compares, with %0d results checked.",
             n_bad, n_cmp, n_out);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
